### src/kot_pkg.sv
// kot_pkg: shared types and constants of the keyword/operator tokenizer
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps

package kot_pkg;

	// offset counter width and length saturation limit
	localparam int OFFSET_BITS  = 16;
	localparam int LENGTH_LIMIT = 4095;
	localparam int COUNT_BITS   = $clog2(LENGTH_LIMIT + 1);

	// token queue between scanner and output stage
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// scanner modes
	localparam logic [1:0] M_IDLE   = 2'd0;
	localparam logic [1:0] M_IDENT  = 2'd1;
	localparam logic [1:0] M_NUMBER = 2'd2;
	localparam logic [1:0] M_OPER   = 2'd3;

	// pending operator codes
	localparam logic [1:0] P_ASSIGN = 2'd0;
	localparam logic [1:0] P_BANG   = 2'd1;
	localparam logic [1:0] P_LT     = 2'd2;
	localparam logic [1:0] P_GT     = 2'd3;

	// token kinds
	localparam logic [4:0] K_EOF       = 5'd0;
	localparam logic [4:0] K_INT       = 5'd1;
	localparam logic [4:0] K_IF        = 5'd2;
	localparam logic [4:0] K_ELSE      = 5'd3;
	localparam logic [4:0] K_IDENT     = 5'd4;
	localparam logic [4:0] K_NUMBER    = 5'd5;
	localparam logic [4:0] K_FLOAT     = 5'd6;
	localparam logic [4:0] K_ASSIGN    = 5'd7;
	localparam logic [4:0] K_EQ        = 5'd8;
	localparam logic [4:0] K_NE        = 5'd9;
	localparam logic [4:0] K_LT        = 5'd10;
	localparam logic [4:0] K_LE        = 5'd11;
	localparam logic [4:0] K_GT        = 5'd12;
	localparam logic [4:0] K_GE        = 5'd13;
	localparam logic [4:0] K_PLUS      = 5'd14;
	localparam logic [4:0] K_MINUS     = 5'd15;
	localparam logic [4:0] K_LBRACE    = 5'd16;
	localparam logic [4:0] K_RBRACE    = 5'd17;
	localparam logic [4:0] K_LPAREN    = 5'd18;
	localparam logic [4:0] K_RPAREN    = 5'd19;
	localparam logic [4:0] K_SEMICOLON = 5'd20;
	localparam logic [4:0] K_UNKNOWN   = 5'd21;

	// keyword prefix states
	localparam logic [3:0] KW_NONE = 4'd0;
	localparam logic [3:0] KW_I    = 4'd1;
	localparam logic [3:0] KW_IN   = 4'd2;
	localparam logic [3:0] KW_INT  = 4'd3;
	localparam logic [3:0] KW_IF   = 4'd4;
	localparam logic [3:0] KW_E    = 4'd5;
	localparam logic [3:0] KW_EL   = 4'd6;
	localparam logic [3:0] KW_ELS  = 4'd7;
	localparam logic [3:0] KW_ELSE = 4'd8;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_input;
	} item_t;

	typedef struct packed {
		logic [4:0]  token_kind;
		logic [15:0] start_offset;
		logic [11:0] token_length;
		logic        last_of_item;
	} token_t;

	// up to two tokens written into the queue per accepted item
	typedef struct packed {
		logic [1:0] n;
		token_t     t0;
		token_t     t1;
	} tok_pair_t;

endpackage

### src/keyword_operator_tokenizer_core.sv
// keyword_operator_tokenizer_core: top level of the streaming tokenizer
// depends on kot_pkg, kot_front, kot_queue, kot_back
//
//   channel   ports                  transfer when
//   input     push, full, item       push && !full
//   result    empty, pop, token      pop && !empty
//
// one source byte per cycle is taken while the token queue has room for two
// tokens; the result register drains one token per cycle while the consumer
// pops, so an item that yields two tokens (a flush plus a single-byte token,
// or a flush plus eof) needs two pops to drain and the queue absorbs the difference
// a token passes the queue and then the result register on its way to the ports
// reset clears scanner state, queue pointers and the result valid flag
`timescale 1ns / 1ps

module keyword_operator_tokenizer_core import kot_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	output logic   full,
	input  item_t  item,
	output logic   empty,
	input  logic   pop,
	output token_t token
);

	logic      accept;
	logic      has_room;
	logic      q_nonempty;
	logic      q_rd;
	token_t    q_head;
	tok_pair_t wr;

	// room for the worst case of two tokens decides full
	assign full   = !has_room;
	assign accept = push && has_room;

	// front: classify byte, update scan state, emit up to two tokens
	kot_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.wr     (wr)
	);

	// decoupling queue between scanner and result register
	kot_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.rd       (q_rd),
		.has_room (has_room),
		.nonempty (q_nonempty),
		.head     (q_head)
	);

	// back: result register facing the consumer
	kot_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (q_head),
		.q_rd       (q_rd),
		.pop        (pop),
		.empty      (empty),
		.token      (token)
	);

endmodule

### src/kot_front.sv
// kot_front: scanner state and byte classification, up to two tokens per item
// depends on kot_pkg
`timescale 1ns / 1ps

module kot_front import kot_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  item_t     item,
	output tok_pair_t wr
);

	logic [OFFSET_BITS-1:0] pos_q, pos_n;
	logic [1:0]             mode_q, mode_n;
	logic [1:0]             pend_q, pend_n;
	logic [3:0]             kw_q, kw_n;
	logic                   dot_q, dot_n;
	logic [OFFSET_BITS-1:0] start_q, start_n;
	logic [COUNT_BITS-1:0]  count_q, count_n, count_ext;

	logic   e0v, e1v, flush_v, taken;
	token_t e0, e1, flush_tok;
	logic [7:0] c;
	logic is_alpha, is_digit, is_space;

	function automatic logic [15:0] off16(input logic [OFFSET_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[15:0];
	endfunction

	function automatic logic [11:0] len12(input logic [COUNT_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[11:0];
	endfunction

	function automatic logic [3:0] kw_next(input logic [3:0] s, input logic [7:0] ch);
		logic [3:0] r;
		r = KW_NONE;
		case (s)
			KW_I: begin
				if (ch == "n") r = KW_IN;
				else if (ch == "f") r = KW_IF;
			end
			KW_IN:  if (ch == "t") r = KW_INT;
			KW_E:   if (ch == "l") r = KW_EL;
			KW_EL:  if (ch == "s") r = KW_ELS;
			KW_ELS: if (ch == "e") r = KW_ELSE;
			default: r = KW_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] single_kind(input logic [1:0] p);
		logic [4:0] k;
		case (p)
			P_ASSIGN: k = K_ASSIGN;
			P_BANG:   k = K_UNKNOWN;
			P_LT:     k = K_LT;
			default:  k = K_GT;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] double_kind(input logic [1:0] p);
		logic [4:0] k;
		case (p)
			P_ASSIGN: k = K_EQ;
			P_BANG:   k = K_NE;
			P_LT:     k = K_LE;
			default:  k = K_GE;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] char_kind(input logic [7:0] ch);
		logic [4:0] k;
		case (ch)
			"+":     k = K_PLUS;
			"-":     k = K_MINUS;
			"{":     k = K_LBRACE;
			"}":     k = K_RBRACE;
			"(":     k = K_LPAREN;
			")":     k = K_RPAREN;
			";":     k = K_SEMICOLON;
			default: k = K_UNKNOWN;
		endcase
		return k;
	endfunction

	assign c        = item.char_code;
	assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	assign is_digit = c >= "0" && c <= "9";
	assign is_space = c == " " || (c >= 8'd9 && c <= 8'd13);

	// saturating length
	assign count_ext = (count_q < COUNT_BITS'(LENGTH_LIMIT)) ? count_q + 1'b1 : count_q;

	// token that the open scan would give if it ended now
	always_comb begin
		flush_v                = mode_q != M_IDLE;
		flush_tok.start_offset = off16(start_q);
		flush_tok.token_length = len12(count_q);
		flush_tok.last_of_item = 1'b0;
		case (mode_q)
			M_IDENT: begin
				if (kw_q == KW_INT)       flush_tok.token_kind = K_INT;
				else if (kw_q == KW_IF)   flush_tok.token_kind = K_IF;
				else if (kw_q == KW_ELSE) flush_tok.token_kind = K_ELSE;
				else                      flush_tok.token_kind = K_IDENT;
			end
			M_NUMBER: flush_tok.token_kind = dot_q ? K_FLOAT : K_NUMBER;
			M_OPER: begin
				flush_tok.token_kind   = single_kind(pend_q);
				flush_tok.token_length = 12'd1;
			end
			default: flush_tok.token_kind = K_EOF;
		endcase
	end

	always_comb begin
		e0v     = 1'b0;
		e1v     = 1'b0;
		e0      = flush_tok;
		e1      = flush_tok;
		taken   = 1'b0;
		pos_n   = pos_q + 1'b1;
		mode_n  = mode_q;
		pend_n  = pend_q;
		kw_n    = kw_q;
		dot_n   = dot_q;
		start_n = start_q;
		count_n = count_q;
		if (item.end_of_input) begin
			e0v     = flush_v;
			e1v     = 1'b1;
			e1.token_kind   = K_EOF;
			e1.start_offset = off16(pos_q);
			e1.token_length = 12'd0;
			pos_n   = '0;
			mode_n  = M_IDLE;
			pend_n  = P_ASSIGN;
			kw_n    = KW_NONE;
			dot_n   = 1'b0;
			start_n = '0;
			count_n = '0;
		end else begin
			case (mode_q)
				M_IDENT: begin
					if (is_alpha || is_digit) begin
						taken   = 1'b1;
						count_n = count_ext;
						kw_n    = kw_next(kw_q, c);
					end
				end
				M_NUMBER: begin
					if (is_digit || (c == "." && !dot_q)) begin
						taken   = 1'b1;
						count_n = count_ext;
						if (!is_digit) dot_n = 1'b1;
					end
				end
				M_OPER: begin
					if (c == "=") begin
						taken  = 1'b1;
						e0v    = 1'b1;
						e0.token_kind   = double_kind(pend_q);
						e0.token_length = 12'd2;
						mode_n = M_IDLE;
					end
				end
				default: taken = 1'b0;
			endcase
			if (!taken) begin
				e0v    = flush_v;
				mode_n = M_IDLE;
				if (is_alpha || is_digit) begin
					mode_n  = is_alpha ? M_IDENT : M_NUMBER;
					start_n = pos_q;
					count_n = COUNT_BITS'(1);
					dot_n   = 1'b0;
					if (is_alpha) begin
						kw_n = (c == "i") ? KW_I : ((c == "e") ? KW_E : KW_NONE);
					end
				end else if (c == "=" || c == "!" || c == "<" || c == ">") begin
					mode_n  = M_OPER;
					start_n = pos_q;
					count_n = COUNT_BITS'(1);
					dot_n   = 1'b0;
					if (c == "=")      pend_n = P_ASSIGN;
					else if (c == "!") pend_n = P_BANG;
					else if (c == "<") pend_n = P_LT;
					else               pend_n = P_GT;
				end else if (!is_space) begin
					e1v = 1'b1;
					e1.token_kind   = char_kind(c);
					e1.start_offset = off16(pos_q);
					e1.token_length = 12'd1;
				end
			end
		end
	end

	// pack emitted tokens to the low slots, mark the final one
	always_comb begin
		wr.n  = {1'b0, e0v} + {1'b0, e1v};
		wr.t0 = e0v ? e0 : e1;
		wr.t1 = e1;
		wr.t0.last_of_item = !(e0v && e1v);
		wr.t1.last_of_item = 1'b1;
		if (!accept) wr.n = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			mode_q  <= M_IDLE;
			pend_q  <= P_ASSIGN;
			kw_q    <= KW_NONE;
			dot_q   <= 1'b0;
			start_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			pos_q   <= pos_n;
			mode_q  <= mode_n;
			pend_q  <= pend_n;
			kw_q    <= kw_n;
			dot_q   <= dot_n;
			start_q <= start_n;
			count_q <= count_n;
		end
	end

endmodule

### src/kot_queue.sv
// kot_queue: short token queue, two writes and one read per cycle
// depends on kot_pkg
`timescale 1ns / 1ps

module kot_queue import kot_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  tok_pair_t wr,
	input  logic      rd,
	output logic      has_room,
	output logic      nonempty,
	output token_t    head
);

	token_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]   wptr_q, rptr_q, wptr_1;
	logic [QCNT_BITS-1:0]   cnt_q;
	logic                   do_rd;

	assign nonempty = cnt_q != '0;
	assign has_room = cnt_q <= QCNT_BITS'(QUEUE_DEPTH - 2);
	assign head     = mem_q[rptr_q];
	assign do_rd    = rd && nonempty;
	assign wptr_1   = wptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (wr.n != 2'd0) mem_q[wptr_q] <= wr.t0;
		if (wr.n == 2'd2) mem_q[wptr_1] <= wr.t1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + QPTR_BITS'(wr.n);
			if (do_rd) rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + QCNT_BITS'(wr.n) - QCNT_BITS'(do_rd);
		end
	end

endmodule

### src/kot_back.sv
// kot_back: result register that presents the oldest token
// depends on kot_pkg
`timescale 1ns / 1ps

module kot_back import kot_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_nonempty,
	input  token_t q_head,
	output logic   q_rd,
	input  logic   pop,
	output logic   empty,
	output token_t token
);

	logic   valid_q;
	token_t tok_q;

	// refill when the register is free or being drained this cycle
	assign q_rd  = q_nonempty && (!valid_q || pop);
	assign empty = !valid_q;
	assign token = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_rd) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) tok_q <= q_head;
	end

endmodule

### tb/tok_checker.sv
`timescale 1ns / 1ps
// tok_checker: passive monitor for the tokenizer; predicts the token stream of every
// accepted source byte and compares each token transfer field by field
// depends on kot_pkg for the item and token types and the kind codes

module tok_checker import kot_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  logic   full,
	input  item_t  item,
	input  logic   empty,
	input  logic   pop,
	input  token_t token,
	output int     mismatches,
	output int     tokens_due
);

	// scanner state as the block should hold it
	logic [OFFSET_BITS-1:0] next_pos;
	logic [1:0]             mode;
	logic [1:0]             op_held;
	logic [3:0]             kw_state;
	logic                   dot_seen;
	logic [OFFSET_BITS-1:0] word_start;
	logic [COUNT_BITS-1:0]  word_len;

	token_t token_forecast[$];
	token_t item_tokens[$];

	function automatic logic is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic [3:0] kw_advance(logic [3:0] s, logic [7:0] c);
		case (s)
			KW_I:   return c == "n" ? KW_IN : (c == "f" ? KW_IF : KW_NONE);
			KW_IN:  return c == "t" ? KW_INT : KW_NONE;
			KW_E:   return c == "l" ? KW_EL : KW_NONE;
			KW_EL:  return c == "s" ? KW_ELS : KW_NONE;
			KW_ELS: return c == "e" ? KW_ELSE : KW_NONE;
			default: return KW_NONE;
		endcase
	endfunction

	function automatic logic [4:0] lone_kind(logic [1:0] op);
		case (op)
			P_ASSIGN: return K_ASSIGN;
			P_BANG:   return K_UNKNOWN;
			P_LT:     return K_LT;
			default:  return K_GT;
		endcase
	endfunction

	function automatic logic [4:0] pair_kind(logic [1:0] op);
		case (op)
			P_ASSIGN: return K_EQ;
			P_BANG:   return K_NE;
			P_LT:     return K_LE;
			default:  return K_GE;
		endcase
	endfunction

	function automatic void clear_state();
		next_pos   = '0;
		mode       = M_IDLE;
		op_held    = P_ASSIGN;
		kw_state   = KW_NONE;
		dot_seen   = 1'b0;
		word_start = '0;
		word_len   = '0;
	endfunction

	function automatic void emit(logic [4:0] kind, logic [OFFSET_BITS-1:0] start,
			logic [COUNT_BITS-1:0] len);
		token_t t;
		t.token_kind   = kind;
		t.start_offset = 16'(start);
		t.token_length = 12'(len);
		t.last_of_item = 1'b0;
		item_tokens.push_back(t);
	endfunction

	function automatic void start_word(logic [1:0] m);
		mode       = m;
		word_start = next_pos;
		word_len   = COUNT_BITS'(1);
		dot_seen   = 1'b0;
	endfunction

	function automatic void grow_word();
		if (word_len < LENGTH_LIMIT)
			word_len = word_len + 1'b1;
	endfunction

	// emit whatever token is still open and fall back to idle
	function automatic void close_word();
		logic [4:0] kind;
		case (mode)
			M_IDENT: begin
				if (kw_state == KW_INT)
					kind = K_INT;
				else if (kw_state == KW_IF)
					kind = K_IF;
				else if (kw_state == KW_ELSE)
					kind = K_ELSE;
				else
					kind = K_IDENT;
				emit(kind, word_start, word_len);
			end
			M_NUMBER: emit(dot_seen ? K_FLOAT : K_NUMBER, word_start, word_len);
			M_OPER:   emit(lone_kind(op_held), word_start, COUNT_BITS'(1));
			default: ;
		endcase
		mode = M_IDLE;
	endfunction

	function automatic void scan_fresh(logic [7:0] c);
		if (is_blank(c))
			return;
		if (is_letter(c)) begin
			start_word(M_IDENT);
			kw_state = c == "i" ? KW_I : (c == "e" ? KW_E : KW_NONE);
			return;
		end
		if (is_digit(c)) begin
			start_word(M_NUMBER);
			return;
		end
		case (c)
			"=": begin start_word(M_OPER); op_held = P_ASSIGN; end
			"!": begin start_word(M_OPER); op_held = P_BANG; end
			"<": begin start_word(M_OPER); op_held = P_LT; end
			">": begin start_word(M_OPER); op_held = P_GT; end
			"+": emit(K_PLUS, next_pos, COUNT_BITS'(1));
			"-": emit(K_MINUS, next_pos, COUNT_BITS'(1));
			"{": emit(K_LBRACE, next_pos, COUNT_BITS'(1));
			"}": emit(K_RBRACE, next_pos, COUNT_BITS'(1));
			"(": emit(K_LPAREN, next_pos, COUNT_BITS'(1));
			")": emit(K_RPAREN, next_pos, COUNT_BITS'(1));
			";": emit(K_SEMICOLON, next_pos, COUNT_BITS'(1));
			default: emit(K_UNKNOWN, next_pos, COUNT_BITS'(1));
		endcase
	endfunction

	// works out the tokens one accepted item causes and queues them
	function automatic void tokenize_item(item_t it);
		logic   taken;
		token_t t;
		taken = 1'b0;
		item_tokens.delete();
		if (it.end_of_input) begin
			close_word();
			emit(K_EOF, next_pos, '0);
			clear_state();
		end else begin
			case (mode)
				M_IDENT:
					if (is_letter(it.char_code) || is_digit(it.char_code)) begin
						grow_word();
						kw_state = kw_advance(kw_state, it.char_code);
						taken = 1'b1;
					end
				M_NUMBER:
					if (is_digit(it.char_code)) begin
						grow_word();
						taken = 1'b1;
					end else if (it.char_code == "." && !dot_seen) begin
						grow_word();
						dot_seen = 1'b1;
						taken = 1'b1;
					end
				M_OPER:
					if (it.char_code == "=") begin
						emit(pair_kind(op_held), word_start, COUNT_BITS'(2));
						mode = M_IDLE;
						taken = 1'b1;
					end
				default: ;
			endcase
			if (!taken) begin
				close_word();
				scan_fresh(it.char_code);
			end
			next_pos = next_pos + 1'b1;
		end
		foreach (item_tokens[i]) begin
			t = item_tokens[i];
			t.last_of_item = (i == item_tokens.size() - 1);
			token_forecast.push_back(t);
		end
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		token_t want;
		if (!arst_n) begin
			clear_state();
			token_forecast.delete();
			mismatches = 0;
		end else begin
			if (push && !full)
				tokenize_item(item);
			if (pop && !empty) begin
				if (token_forecast.size() == 0) begin
					$error("token with none expected: kind %0d offset %0d length %0d",
						token.token_kind, token.start_offset, token.token_length);
					mismatches++;
				end else begin
					want = token_forecast.pop_front();
					check_field("token_kind", want.token_kind, token.token_kind);
					check_field("start_offset", want.start_offset, token.start_offset);
					check_field("token_length", want.token_length, token.token_length);
					check_field("last_of_item", want.last_of_item, token.last_of_item);
				end
			end
		end
		tokens_due = token_forecast.size();
	end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// tb: stimulus and verdict for keyword_operator_tokenizer_core; prediction and
// comparison live in tok_checker; depends on kot_pkg, the block and tok_checker

module tb;
	import kot_pkg::*;

	// longest run of cycles with no transfer on either side before giving up;
	// it is larger than the deliberate receiver hold-off, HOLD_CYCLES
	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 1800;
	localparam int HOLD_CYCLES = 400;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   push = 1'b0;
	logic   pop = 1'b0;
	item_t  item = '0;
	logic   full;
	logic   empty;
	token_t token;
	int     mismatches;
	int     tokens_due;

	// count of accepted items
	int items_in = 0;
	// set while the sender must not idle
	bit steady_send = 1'b0;

	// word and operator spellings that drive the keyword and operator paths
	string kw_words[12] = '{"int", "if", "else", "in", "i", "e", "el", "els",
		"intx", "iff", "elsee", "int9"};
	string op_words[15] = '{"=", "==", "!", "!=", "<", "<=", ">", ">=", "+", "-",
		"{", "}", "(", ")", ";"};
	logic [7:0] blank_set[6] = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32};

	always #5 clk = ~clk;

	keyword_operator_tokenizer_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.token  (token)
	);

	tok_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.token      (token),
		.mismatches (mismatches),
		.tokens_due (tokens_due)
	);

	function automatic logic [7:0] pick(string set);
		return set[$urandom_range(set.len() - 1)];
	endfunction

	// letters lean toward the keyword alphabet so prefixes like "in" and "els" show up
	function automatic logic [7:0] pick_letter();
		if ($urandom_range(1))
			return pick("intfelsIE");
		return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
	endfunction

	function automatic logic [7:0] pick_alnum();
		return $urandom_range(2) == 0 ? 8'("0" + $urandom_range(9)) : pick_letter();
	endfunction

	// one source byte transfer; called at a falling edge and returns at one,
	// so push is never lowered and raised in the same time step
	task automatic send_byte(logic [7:0] c, logic eoi);
		while (!steady_send && $urandom_range(99) < 31) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= '{char_code: c, end_of_input: eoi};
		do @(posedge clk); while (full);
		items_in++;
		@(negedge clk);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], 1'b0);
	endtask

	// end marker carries a random byte, which the block must ignore
	task automatic end_source();
		send_byte(8'($urandom_range(255)), 1'b1);
	endtask

	// one random lexeme, sometimes followed by a blank; no blank lets neighbors
	// run into each other, one source of two-token items
	task automatic send_lexeme();
		case ($urandom_range(9))
			0, 1: send_text(kw_words[$urandom_range(11)]);
			2, 3: begin
				send_byte(pick_letter(), 1'b0);
				repeat ($urandom_range(6)) send_byte(pick_alnum(), 1'b0);
			end
			4, 5: begin
				repeat ($urandom_range(1, 4)) send_byte(8'("0" + $urandom_range(9)), 1'b0);
				if ($urandom_range(1)) begin
					send_byte(".", 1'b0);
					repeat ($urandom_range(3)) send_byte(8'("0" + $urandom_range(9)), 1'b0);
					// second dot ends the number and comes back as unknown
					if ($urandom_range(3) == 0)
						send_byte(".", 1'b0);
				end
			end
			6, 7, 8: send_text(op_words[$urandom_range(14)]);
			default: send_byte(8'($urandom_range(255)), 1'b0);
		endcase
		if ($urandom_range(1))
			send_byte(blank_set[$urandom_range(5)], 1'b0);
	endtask

	// watchdog: ends the run when neither side moves for too long
	always @(posedge clk) begin
		int quiet;
		if (!arst_n)
			quiet = 0;
		else if ((push && !full) || (pop && !empty))
			quiet = 0;
		else begin
			quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// receiver: random pops, one steady window, and one long hold-off while the
	// sender keeps pushing so the token queue fills and full rises
	initial begin
		int  cyc;
		bit  held;
		cyc  = 0;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (!held && items_in >= 300) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			pop <= (cyc >= 2000 && cyc < 3000) || ($urandom_range(99) >= 31);
		end
	end

	// sender
	initial begin
		int first;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// end marker straight after reset: eof alone at offset 0
		end_source();
		// float, second dot as unknown, then a plain number
		send_text("1.2.3");
		end_source();
		// lone bang before a letter, identifier, trailing less-than at end
		send_text("!a<");
		end_source();
		// extreme bytes, then a lone bang flushed by the end marker
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_text("!");
		end_source();
		// not-equal right after an identifier
		send_text("e!=");
		end_source();
		// trailing assign and trailing greater-than
		send_text("=");
		end_source();
		send_text(">");
		end_source();

		// random sources of well-formed lexemes mixed with noise bytes
		first = items_in;
		while (items_in - first < RANDOM_ITEMS) begin
			steady_send = (items_in - first >= 300) && (items_in - first < 700);
			repeat ($urandom_range(1, 12)) send_lexeme();
			end_source();
		end
		steady_send = 1'b0;
		push <= 1'b0;

		// drain, then keep watching so that any stray token would still be caught
		while (tokens_due != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
